// ===== design/acp_pkg.sv =====
// Shared types and constants for the AABB contact and pushback core.
`timescale 1ns / 1ps

package acp_pkg;

   localparam int COORD_BITS     = 16;
   localparam int DAMP_FRAC_BITS = 8;
   localparam int DAMP_BITS      = DAMP_FRAC_BITS + 1;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = DAMP_BITS;
   localparam int FLAG_BITS      = 8;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_BITS-1:0] CSR_SELF_EN     = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_DAMPING     = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_CORNER_PREF = CSR_IDX_BITS'(2);

   localparam logic [DAMP_BITS-1:0] DAMP_ONE = DAMP_BITS'(1 << DAMP_FRAC_BITS);

   localparam logic [1:0] PREF_X = 2'd0;
   localparam logic [1:0] PREF_Y = 2'd1;

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_HIT   = 2'd1,
      OP_PUSH  = 2'd2,
      OP_FINAL = 2'd3
   } op_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   span_type;

   typedef struct packed {
      op_type    opcode;
      coord_type left;
      coord_type right;
      coord_type top;
      coord_type bottom;
      logic      vx_pos;
      logic      vy_pos;
      logic      opp_en;
      span_type  width;
      span_type  height;
   } item_type;

   typedef struct packed {
      logic                 self_en;
      logic [DAMP_BITS-1:0] damping;
      logic [1:0]           pref;
   } cfg_type;

endpackage

// ===== design/acp_if.sv =====
// Handshake interfaces for the request, response and register write channels.
`timescale 1ns / 1ps

interface acp_req_if import acp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            opcode;
   logic [COORD_BITS-1:0] box_left;
   logic [COORD_BITS-1:0] box_right;
   logic [COORD_BITS-1:0] box_top;
   logic [COORD_BITS-1:0] box_bottom;
   logic                  vx_positive;
   logic                  vy_positive;
   logic                  opp_enabled;

   modport source (output valid, opcode, box_left, box_right, box_top, box_bottom,
                   vx_positive, vy_positive, opp_enabled, input ready);
   modport sink (input valid, opcode, box_left, box_right, box_top, box_bottom,
                 vx_positive, vy_positive, opp_enabled, output ready);
endinterface

interface acp_rsp_if import acp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [FLAG_BITS-1:0]  contact_flags;
   logic [COORD_BITS-1:0] pushback_x;
   logic [COORD_BITS-1:0] pushback_y;
   logic [COORD_BITS-1:0] overlap_peak_x;
   logic [COORD_BITS-1:0] overlap_peak_y;
   logic                  fully_blocked;
   logic                  skipped_unsupported;

   modport source (output valid, hit, contact_flags, pushback_x, pushback_y,
                   overlap_peak_x, overlap_peak_y, fully_blocked, skipped_unsupported,
                   input ready);
   modport sink (input valid, hit, contact_flags, pushback_x, pushback_y,
                 overlap_peak_x, overlap_peak_y, fully_blocked, skipped_unsupported,
                 output ready);
endinterface

interface acp_csr_if import acp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/acp_front.sv =====
// Front end: request intake, opcode decode, opponent size and register file.
`timescale 1ns / 1ps

module acp_front import acp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   acp_req_if.sink   req_port,
   acp_csr_if.sink   csr_port,
   input  logic      queue_full,
   output logic      push,
   output item_type  item,
   output cfg_type   cfg
);

   logic                 self_en_ff, self_en_in;
   logic [DAMP_BITS-1:0] damping_ff, damping_in;
   logic [1:0]           pref_ff, pref_in;
   logic                 csr_write;

   assign req_port.ready = !queue_full;
   assign push           = req_port.valid && !queue_full;

   always_comb begin
      item.opcode = op_type'(req_port.opcode);
      item.left   = coord_type'(req_port.box_left);
      item.right  = coord_type'(req_port.box_right);
      item.top    = coord_type'(req_port.box_top);
      item.bottom = coord_type'(req_port.box_bottom);
      item.vx_pos = req_port.vx_positive;
      item.vy_pos = req_port.vy_positive;
      item.opp_en = req_port.opp_enabled;
      item.width  = span_type'(item.right) - span_type'(item.left);
      item.height = span_type'(item.bottom) - span_type'(item.top);
   end

   assign csr_port.ready = 1'b1;
   assign csr_write      = csr_port.valid;

   always_comb begin
      self_en_in = self_en_ff;
      damping_in = damping_ff;
      pref_in    = pref_ff;
      if (csr_write) begin
         case (csr_port.index)
            CSR_SELF_EN:     self_en_in = csr_port.data[0];
            CSR_DAMPING:     damping_in = csr_port.data[DAMP_BITS-1:0];
            CSR_CORNER_PREF: pref_in    = csr_port.data[1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         self_en_ff <= 1'b1;
         damping_ff <= DAMP_ONE;
         pref_ff    <= PREF_X;
      end else begin
         self_en_ff <= self_en_in;
         damping_ff <= damping_in;
         pref_ff    <= pref_in;
      end
   end

   assign cfg.self_en = self_en_ff;
   assign cfg.damping = damping_ff;
   assign cfg.pref    = pref_ff;

endmodule

// ===== design/acp_queue.sv =====
// Short FIFO between the front end and the execution back end.
`timescale 1ns / 1ps

module acp_queue import acp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     not_empty,
   output logic     full,
   output item_type head
);

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/acp_back.sv =====
// Back end: contact flags, damped pushback and frame state, response register.
`timescale 1ns / 1ps

module acp_back import acp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   input  cfg_type  cfg,
   output logic     pop,
   acp_rsp_if.source rsp_port
);

   localparam logic [3:0] CRN_LT = 4'b0001;
   localparam logic [3:0] CRN_RT = 4'b0010;
   localparam logic [3:0] CRN_LB = 4'b0100;
   localparam logic [3:0] CRN_RB = 4'b1000;
   localparam int F_LT = 0;
   localparam int F_RT = 1;
   localparam int F_LB = 2;
   localparam int F_RB = 3;
   localparam int F_L  = 4;
   localparam int F_R  = 5;
   localparam int F_T  = 6;
   localparam int F_B  = 7;
   localparam coord_type PUSH_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

   typedef logic signed [COORD_BITS+1:0] ovl_type;

   function automatic logic in_box(input coord_type px, input coord_type py,
                                   input coord_type l, input coord_type r,
                                   input coord_type t, input coord_type b);
      return (l <= px) && (px <= r) && (t <= py) && (py <= b);
   endfunction

   function automatic logic [COORD_BITS-1:0] sat_overlap(input coord_type hi,
                                                         input coord_type lo);
      ovl_type d;
      d = ovl_type'(hi) - ovl_type'(lo) + ovl_type'(1);
      if (d[COORD_BITS+1]) begin
         return '0;
      end else if (d[COORD_BITS]) begin
         return '1;
      end
      return d[COORD_BITS-1:0];
   endfunction

   function automatic coord_type damped(input logic [COORD_BITS-1:0] o,
                                        input logic [DAMP_BITS-1:0] damp);
      logic [COORD_BITS+DAMP_BITS-1:0] p;
      logic [COORD_BITS:0]             sh;
      p  = o * damp;
      sh = p[COORD_BITS+DAMP_BITS-1:DAMP_FRAC_BITS];
      if (sh[COORD_BITS] || sh[COORD_BITS-1]) begin
         return PUSH_MAX;
      end
      return coord_type'(sh[COORD_BITS-1:0]);
   endfunction

   // neg = 0 keeps the largest positive value, neg = 1 the most negative
   function automatic coord_type keep(input coord_type dst, input coord_type v,
                                      input logic neg);
      if (!neg) begin
         return (v > 0 && dst < v) ? v : dst;
      end
      return (v < 0 && dst > v) ? v : dst;
   endfunction

   coord_type                 self_left_ff, self_left_in;
   coord_type                 self_right_ff, self_right_in;
   coord_type                 self_top_ff, self_top_in;
   coord_type                 self_bottom_ff, self_bottom_in;
   logic                      self_vx_pos_ff, self_vx_pos_in;
   logic                      self_vy_pos_ff, self_vy_pos_in;
   logic [FLAG_BITS-1:0]      flags_ff, flags_in;
   coord_type                 push_x_ff, push_x_in;
   coord_type                 push_y_ff, push_y_in;
   logic [COORD_BITS-1:0]     peak_x_ff, peak_x_in;
   logic [COORD_BITS-1:0]     peak_y_ff, peak_y_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic                      rsp_skip_ff, rsp_skip_in;

   logic                      fire;
   logic                      overlap;
   logic [FLAG_BITS-1:0]      contact;
   logic [3:0]                corners;
   logic [COORD_BITS-1:0]     ox, oy;
   coord_type                 nx, ny;
   logic                      self_too_big;
   logic                      corner_kind;
   logic                      sx_neg, sy_neg;
   coord_type                 kx, ky;

   assign fire = item_valid && (!rsp_valid_ff || rsp_port.ready);
   assign pop  = fire;

   assign overlap = (self_left_ff <= item.right) && (item.left <= self_right_ff) &&
                    (self_top_ff <= item.bottom) && (item.top <= self_bottom_ff);

   always_comb begin
      contact = '0;
      if (in_box(self_left_ff, self_top_ff, item.left, item.right, item.top,
                 item.bottom)) begin
         contact[F_LT] = 1'b1; contact[F_L] = 1'b1; contact[F_T] = 1'b1;
      end
      if (in_box(self_right_ff, self_top_ff, item.left, item.right, item.top,
                 item.bottom)) begin
         contact[F_RT] = 1'b1; contact[F_R] = 1'b1; contact[F_T] = 1'b1;
      end
      if (in_box(self_left_ff, self_bottom_ff, item.left, item.right, item.top,
                 item.bottom)) begin
         contact[F_LB] = 1'b1; contact[F_L] = 1'b1; contact[F_B] = 1'b1;
      end
      if (in_box(self_right_ff, self_bottom_ff, item.left, item.right, item.top,
                 item.bottom)) begin
         contact[F_RB] = 1'b1; contact[F_R] = 1'b1; contact[F_B] = 1'b1;
      end
      // opponent lies strictly inside self vertically: side edges only
      if (self_top_ff < item.top && item.bottom < self_bottom_ff) begin
         if (item.left <= self_left_ff && self_left_ff <= item.right) contact[F_L] = 1'b1;
         if (item.left <= self_right_ff && self_right_ff <= item.right) contact[F_R] = 1'b1;
      end
      if (self_left_ff < item.left && item.right < self_right_ff) begin
         if (item.top <= self_top_ff && self_top_ff <= item.bottom) contact[F_T] = 1'b1;
         if (item.top <= self_bottom_ff && self_bottom_ff <= item.bottom) contact[F_B] = 1'b1;
      end
   end

   assign self_too_big =
      ((span_type'(self_right_ff) - span_type'(self_left_ff)) > item.width) ||
      ((span_type'(self_bottom_ff) - span_type'(self_top_ff)) > item.height);

   assign ox = sat_overlap((self_right_ff < item.right) ? self_right_ff : item.right,
                           (self_left_ff > item.left) ? self_left_ff : item.left);
   assign oy = sat_overlap((self_bottom_ff < item.bottom) ? self_bottom_ff : item.bottom,
                           (self_top_ff > item.top) ? self_top_ff : item.top);

   always_comb begin
      kx = damped(ox, cfg.damping);
      ky = damped(oy, cfg.damping);
      nx = (item.left <= self_right_ff && self_right_ff < item.right) ? -kx : kx;
      ny = (item.top <= self_bottom_ff && self_bottom_ff < item.bottom) ? -ky : ky;
   end

   assign corners = flags_ff[3:0];

   always_comb begin
      self_left_in   = self_left_ff;
      self_right_in  = self_right_ff;
      self_top_in    = self_top_ff;
      self_bottom_in = self_bottom_ff;
      self_vx_pos_in = self_vx_pos_ff;
      self_vy_pos_in = self_vy_pos_ff;
      flags_in       = flags_ff;
      push_x_in      = push_x_ff;
      push_y_in      = push_y_ff;
      peak_x_in      = peak_x_ff;
      peak_y_in      = peak_y_ff;
      rsp_hit_in     = 1'b0;
      rsp_skip_in    = 1'b0;
      corner_kind    = 1'b0;
      sx_neg         = 1'b0;
      sy_neg         = 1'b0;

      case (item.opcode)
         OP_BEGIN: begin
            self_left_in   = item.left;
            self_right_in  = item.right;
            self_top_in    = item.top;
            self_bottom_in = item.bottom;
            self_vx_pos_in = item.vx_pos;
            self_vy_pos_in = item.vy_pos;
            flags_in       = '0;
            push_x_in      = '0;
            push_y_in      = '0;
            peak_x_in      = '0;
            peak_y_in      = '0;
         end
         OP_HIT: begin
            if (cfg.self_en && item.opp_en && overlap) begin
               rsp_hit_in = 1'b1;
               flags_in   = flags_ff | contact;
            end
         end
         OP_PUSH: begin
            if (self_too_big) begin
               rsp_skip_in = 1'b1;
            end else if (overlap) begin
               if (ox > peak_x_ff) peak_x_in = ox;
               if (oy > peak_y_ff) peak_y_in = oy;
               case (corners)
                  CRN_LT, CRN_LT | CRN_RT | CRN_LB: begin
                     corner_kind = 1'b1; sx_neg = 1'b0; sy_neg = 1'b0;
                  end
                  CRN_RT, CRN_LT | CRN_RT | CRN_RB: begin
                     corner_kind = 1'b1; sx_neg = 1'b1; sy_neg = 1'b0;
                  end
                  CRN_RB, CRN_RT | CRN_LB | CRN_RB: begin
                     corner_kind = 1'b1; sx_neg = 1'b1; sy_neg = 1'b1;
                  end
                  CRN_LB, CRN_LT | CRN_LB | CRN_RB: begin
                     corner_kind = 1'b1; sx_neg = 1'b0; sy_neg = 1'b1;
                  end
                  CRN_LT | CRN_RT: push_y_in = keep(push_y_ff, ny, 1'b0);
                  CRN_RT | CRN_RB: push_x_in = keep(push_x_ff, nx, 1'b1);
                  CRN_LB | CRN_RB: push_y_in = keep(push_y_ff, ny, 1'b1);
                  CRN_LT | CRN_LB: push_x_in = keep(push_x_ff, nx, 1'b0);
                  CRN_RT | CRN_LB, CRN_LT | CRN_RB: begin
                     push_x_in = keep(push_x_ff, nx, self_vx_pos_ff);
                     push_y_in = keep(push_y_ff, ny, self_vy_pos_ff);
                  end
                  default: ;
               endcase
               if (corner_kind) begin
                  if (ox < oy || (ox == oy && cfg.pref == PREF_X)) begin
                     push_x_in = keep(push_x_ff, nx, sx_neg);
                  end else if (ox > oy || (ox == oy && cfg.pref == PREF_Y)) begin
                     push_y_in = keep(push_y_ff, ny, sy_neg);
                  end else begin
                     push_x_in = keep(push_x_ff, nx, sx_neg);
                     push_y_in = keep(push_y_ff, ny, sy_neg);
                  end
               end
            end
         end
         OP_FINAL: begin
            case (corners)
               CRN_LT | CRN_RT, CRN_LB | CRN_RB: push_x_in = '0;
               CRN_RT | CRN_RB, CRN_LT | CRN_LB: push_y_in = '0;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         self_left_ff   <= '0;
         self_right_ff  <= '0;
         self_top_ff    <= '0;
         self_bottom_ff <= '0;
         self_vx_pos_ff <= 1'b0;
         self_vy_pos_ff <= 1'b0;
         flags_ff       <= '0;
         push_x_ff      <= '0;
         push_y_ff      <= '0;
         peak_x_ff      <= '0;
         peak_y_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            self_left_ff   <= self_left_in;
            self_right_ff  <= self_right_in;
            self_top_ff    <= self_top_in;
            self_bottom_ff <= self_bottom_in;
            self_vx_pos_ff <= self_vx_pos_in;
            self_vy_pos_ff <= self_vy_pos_in;
            flags_ff       <= flags_in;
            push_x_ff      <= push_x_in;
            push_y_ff      <= push_y_in;
            peak_x_ff      <= peak_x_in;
            peak_y_ff      <= peak_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_hit_ff  <= rsp_hit_in;
         rsp_skip_ff <= rsp_skip_in;
      end
   end

   // frame state doubles as the response payload, it only moves on fire
   assign rsp_port.valid               = rsp_valid_ff;
   assign rsp_port.hit                 = rsp_hit_ff;
   assign rsp_port.contact_flags       = flags_ff;
   assign rsp_port.pushback_x          = push_x_ff;
   assign rsp_port.pushback_y          = push_y_ff;
   assign rsp_port.overlap_peak_x      = peak_x_ff;
   assign rsp_port.overlap_peak_y      = peak_y_ff;
   assign rsp_port.fully_blocked       = &flags_ff[3:0];
   assign rsp_port.skipped_unsupported = rsp_skip_ff;

endmodule

// ===== design/aabb_contact_pushback_core.sv =====
// AABB contact and pushback core: top level.
`timescale 1ns / 1ps

// Resolves box contacts per frame: begin, hit test, pushback and finalize
// transactions, one response per request. A request is accepted every cycle
// while the two-entry request queue has room. The back end takes one request
// per cycle from the queue head while the output register is free or being
// taken, runs it on the frame state left by the previous one and registers
// its response; the sustained rate of one transaction per cycle is set by how
// fast the response side takes results. Register writes take effect the cycle
// after the write and are meant to happen while no request is outstanding.
module aabb_contact_pushback_core import acp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   acp_req_if.sink   req_port,
   acp_rsp_if.source rsp_port,
   acp_csr_if.sink   csr_port
);

   logic     push;
   logic     pop;
   logic     queue_full;
   logic     queue_not_empty;
   item_type front_item;
   item_type head_item;
   cfg_type  cfg;

   acp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .csr_port   (csr_port),
      .queue_full (queue_full),
      .push       (push),
      .item       (front_item),
      .cfg        (cfg)
   );

   acp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .full      (queue_full),
      .head      (head_item)
   );

   acp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (head_item),
      .cfg        (cfg),
      .pop        (pop),
      .rsp_port   (rsp_port)
   );

endmodule

// ===== design/acp_checker.sv =====
// Port-level checks for the AABB contact and pushback core, bound to the top.
`timescale 1ns / 1ps

module acp_checker import acp_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_hit,
   input logic [FLAG_BITS-1:0] rsp_flags,
   input logic                 rsp_blocked,
   input logic                 rsp_skipped
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_flags) && $stable(rsp_hit))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_blocked == (&rsp_flags[3:0]))
      else $error("fully_blocked disagrees with corner flags");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_skipped))
      else $error("hit and skip in one response");

endmodule

bind aabb_contact_pushback_core acp_checker u_acp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .rsp_hit     (rsp_port.hit),
   .rsp_flags   (rsp_port.contact_flags),
   .rsp_blocked (rsp_port.fully_blocked),
   .rsp_skipped (rsp_port.skipped_unsupported)
);

// ===== sim/aabb_contact_pushback_checker.sv =====
// Checker for the contact core: tracks frame state, predicts each response and compares it.
`timescale 1ns / 1ps

module aabb_contact_pushback_checker import acp_pkg::*; (
   input  logic clock,
   input  logic reset,
   acp_req_if   req_mon,
   acp_rsp_if   rsp_mon,
   acp_csr_if   csr_mon,
   output int   error_count,
   output int   results_due
);

   localparam logic [3:0] C_LT = 4'h1;
   localparam logic [3:0] C_RT = 4'h2;
   localparam logic [3:0] C_LB = 4'h4;
   localparam logic [3:0] C_RB = 4'h8;
   localparam logic [7:0] E_L  = 8'h10;
   localparam logic [7:0] E_R  = 8'h20;
   localparam logic [7:0] E_T  = 8'h40;
   localparam logic [7:0] E_B  = 8'h80;

   localparam longint OVERLAP_CAP = (longint'(1) << COORD_BITS) - 1;
   localparam longint PUSH_CAP    = (longint'(1) << (COORD_BITS - 1)) - 1;

   typedef struct {
      logic                  hit;
      logic [FLAG_BITS-1:0]  flags;
      logic [COORD_BITS-1:0] push_x;
      logic [COORD_BITS-1:0] push_y;
      logic [COORD_BITS-1:0] peak_x;
      logic [COORD_BITS-1:0] peak_y;
      logic                  blocked;
      logic                  skipped;
   } contact_result_type;

   logic                 self_en;
   logic [DAMP_BITS-1:0] damp;
   logic [1:0]           pref;

   longint               self_l, self_r, self_t, self_b;
   logic                 vx_pos, vy_pos;
   logic [7:0]           flags;
   longint               push_x, push_y, peak_x, peak_y;

   contact_result_type   responses_due[$];
   contact_result_type   want;
   contact_result_type   fresh;

   function automatic longint clip_overlap(longint hi, longint lo);
      longint o;
      o = hi - lo + 1;
      if (o < 0) o = 0;
      if (o > OVERLAP_CAP) o = OVERLAP_CAP;
      return o;
   endfunction

   function automatic longint damp_push(longint o);
      longint p;
      p = (o * longint'(damp)) >>> DAMP_FRAC_BITS;
      if (p > PUSH_CAP) p = PUSH_CAP;
      return p;
   endfunction

   // dir > 0 keeps the largest positive value, dir < 0 the most negative
   function automatic longint keep_extreme(longint cur, longint v, int dir);
      if (dir > 0) return (v > 0 && cur < v) ? v : cur;
      return (v < 0 && cur > v) ? v : cur;
   endfunction

   function automatic bit covers(longint px, longint py,
                                 longint l, longint r, longint t, longint b);
      return l <= px && px <= r && t <= py && py <= b;
   endfunction

   function automatic bit boxes_touch(longint l, longint r, longint t, longint b);
      return self_l <= r && l <= self_r && self_t <= b && t <= self_b;
   endfunction

   function automatic logic [7:0] contact_bits(longint l, longint r, longint t, longint b);
      logic [7:0] f;
      f = '0;
      if (covers(self_l, self_t, l, r, t, b)) f |= {4'h0, C_LT} | E_L | E_T;
      if (covers(self_r, self_t, l, r, t, b)) f |= {4'h0, C_RT} | E_R | E_T;
      if (covers(self_l, self_b, l, r, t, b)) f |= {4'h0, C_LB} | E_L | E_B;
      if (covers(self_r, self_b, l, r, t, b)) f |= {4'h0, C_RB} | E_R | E_B;
      if (self_t < t && b < self_b) begin
         if (l <= self_l && self_l <= r) f |= E_L;
         if (l <= self_r && self_r <= r) f |= E_R;
      end
      if (self_l < l && r < self_r) begin
         if (t <= self_t && self_t <= b) f |= E_T;
         if (t <= self_b && self_b <= b) f |= E_B;
      end
      return f;
   endfunction

   function automatic void apply_pushback(longint l, longint r, longint t, longint b);
      longint ox, oy, nx, ny;
      int     sx, sy;
      bit     one_corner;
      ox = clip_overlap((self_r < r) ? self_r : r, (self_l > l) ? self_l : l);
      oy = clip_overlap((self_b < b) ? self_b : b, (self_t > t) ? self_t : t);
      if (ox > peak_x) peak_x = ox;
      if (oy > peak_y) peak_y = oy;
      nx = damp_push(ox);
      if (l <= self_r && self_r < r) nx = -nx;
      ny = damp_push(oy);
      if (t <= self_b && self_b < b) ny = -ny;
      one_corner = 1'b0;
      sx = 0;
      sy = 0;
      case (flags[3:0])
         C_LT, C_LT | C_RT | C_LB: begin
            one_corner = 1'b1; sx = 1;  sy = 1;
         end
         C_RT, C_LT | C_RT | C_RB: begin
            one_corner = 1'b1; sx = -1; sy = 1;
         end
         C_RB, C_RT | C_LB | C_RB: begin
            one_corner = 1'b1; sx = -1; sy = -1;
         end
         C_LB, C_LT | C_LB | C_RB: begin
            one_corner = 1'b1; sx = 1;  sy = -1;
         end
         C_LT | C_RT: push_y = keep_extreme(push_y, ny, 1);
         C_RT | C_RB: push_x = keep_extreme(push_x, nx, -1);
         C_LB | C_RB: push_y = keep_extreme(push_y, ny, -1);
         C_LT | C_LB: push_x = keep_extreme(push_x, nx, 1);
         C_RT | C_LB, C_LT | C_RB: begin
            push_x = keep_extreme(push_x, nx, vx_pos ? -1 : 1);
            push_y = keep_extreme(push_y, ny, vy_pos ? -1 : 1);
         end
         default: ;
      endcase
      if (one_corner) begin
         if (ox < oy || (ox == oy && pref == PREF_X)) begin
            push_x = keep_extreme(push_x, nx, sx);
         end else if (ox > oy || (ox == oy && pref == PREF_Y)) begin
            push_y = keep_extreme(push_y, ny, sy);
         end else begin
            push_x = keep_extreme(push_x, nx, sx);
            push_y = keep_extreme(push_y, ny, sy);
         end
      end
   endfunction

   function automatic contact_result_type resolve_contact_item(
      op_type op, longint l, longint r, longint t, longint b,
      logic vx, logic vy, logic opp_en);
      contact_result_type res;
      res.hit     = 1'b0;
      res.skipped = 1'b0;
      case (op)
         OP_BEGIN: begin
            self_l = l; self_r = r; self_t = t; self_b = b;
            vx_pos = vx;
            vy_pos = vy;
            flags  = '0;
            push_x = 0; push_y = 0;
            peak_x = 0; peak_y = 0;
         end
         OP_HIT: begin
            if (self_en && opp_en && boxes_touch(l, r, t, b)) begin
               res.hit = 1'b1;
               flags |= contact_bits(l, r, t, b);
            end
         end
         OP_PUSH: begin
            if ((self_r - self_l) > (r - l) || (self_b - self_t) > (b - t))
               res.skipped = 1'b1;
            else if (boxes_touch(l, r, t, b))
               apply_pushback(l, r, t, b);
         end
         default: begin
            case (flags[3:0])
               C_LT | C_RT, C_LB | C_RB: push_x = 0;
               C_RT | C_RB, C_LT | C_LB: push_y = 0;
               default: ;
            endcase
         end
      endcase
      res.flags   = flags;
      res.push_x  = push_x[COORD_BITS-1:0];
      res.push_y  = push_y[COORD_BITS-1:0];
      res.peak_x  = peak_x[COORD_BITS-1:0];
      res.peak_y  = peak_y[COORD_BITS-1:0];
      res.blocked = &flags[3:0];
      return res;
   endfunction

   function automatic void check_field(string name, longint expected, longint actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         self_en = 1'b1;
         damp    = DAMP_ONE;
         pref    = PREF_X;
         self_l = 0; self_r = 0; self_t = 0; self_b = 0;
         vx_pos = 1'b0; vy_pos = 1'b0;
         flags  = '0;
         push_x = 0; push_y = 0;
         peak_x = 0; peak_y = 0;
         responses_due.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_SELF_EN:     self_en = csr_mon.data[0];
               CSR_DAMPING:     damp    = csr_mon.data[DAMP_BITS-1:0];
               CSR_CORNER_PREF: pref    = csr_mon.data[1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            fresh = resolve_contact_item(op_type'(req_mon.opcode),
                                         longint'($signed(req_mon.box_left)),
                                         longint'($signed(req_mon.box_right)),
                                         longint'($signed(req_mon.box_top)),
                                         longint'($signed(req_mon.box_bottom)),
                                         req_mon.vx_positive, req_mon.vy_positive,
                                         req_mon.opp_enabled);
            responses_due.push_back(fresh);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (responses_due.size() == 0) begin
               $error("response transaction with no prediction pending");
               error_count++;
            end else begin
               want = responses_due.pop_front();
               check_field("hit", longint'(want.hit), longint'(rsp_mon.hit));
               check_field("contact_flags", longint'(want.flags),
                           longint'(rsp_mon.contact_flags));
               check_field("pushback_x", longint'(want.push_x),
                           longint'(rsp_mon.pushback_x));
               check_field("pushback_y", longint'(want.push_y),
                           longint'(rsp_mon.pushback_y));
               check_field("overlap_peak_x", longint'(want.peak_x),
                           longint'(rsp_mon.overlap_peak_x));
               check_field("overlap_peak_y", longint'(want.peak_y),
                           longint'(rsp_mon.overlap_peak_y));
               check_field("fully_blocked", longint'(want.blocked),
                           longint'(rsp_mon.fully_blocked));
               check_field("skipped_unsupported", longint'(want.skipped),
                           longint'(rsp_mon.skipped_unsupported));
            end
         end
      end
      results_due = responses_due.size();
   end

endmodule

// ===== sim/aabb_contact_pushback_core_tb.sv =====
// Testbench top for the contact core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module aabb_contact_pushback_core_tb;
   import acp_pkg::*;

   localparam logic [1:0] PREF_BOTH  = 2'd2;
   localparam logic [1:0] PREF_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   results_due;
   int   items_sent = 0;
   int   stall_left = 0;
   bit   idling     = 1'b1;

   acp_req_if req_port ();
   acp_rsp_if rsp_port ();
   acp_csr_if csr_port ();

   aabb_contact_pushback_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port),
      .csr_port (csr_port)
   );

   aabb_contact_pushback_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_port),
      .rsp_mon     (rsp_port),
      .csr_mon     (csr_port),
      .error_count (error_count),
      .results_due (results_due)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("aabb_contact_pushback_core_tb: errors");
      $finish;
   end

   // response side back-pressure
   initial begin
      rsp_port.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left     <= stall_left - 1;
            rsp_port.ready <= 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left     <= $urandom_range(0, 2);
            rsp_port.ready <= 1'b0;
         end else begin
            rsp_port.ready <= 1'b1;
         end
      end
   end

   function automatic logic [COORD_BITS-1:0] to_coord(int v);
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v[COORD_BITS-1:0];
   endfunction

   function automatic int any_coord();
      return int'($signed(16'($urandom)));
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic send_req(op_type op, int l, int r, int t, int b,
                           logic vx, logic vy, logic opp_en);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_port.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_port.valid       <= 1'b1;
      req_port.opcode      <= op;
      req_port.box_left    <= to_coord(l);
      req_port.box_right   <= to_coord(r);
      req_port.box_top     <= to_coord(t);
      req_port.box_bottom  <= to_coord(b);
      req_port.vx_positive <= vx;
      req_port.vy_positive <= vy;
      req_port.opp_enabled <= opp_en;
      @(negedge clock);
      while (!req_port.ready) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drain();
      req_port.valid <= 1'b0;
      @(negedge clock);
      while (results_due != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, int value);
      csr_port.valid <= 1'b1;
      csr_port.index <= idx;
      csr_port.data  <= CSR_DATA_BITS'(value);
      @(negedge clock);
      while (!csr_port.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic set_config(logic en, int damp, logic [1:0] pref);
      wait_drain();
      csr_write(CSR_SELF_EN, en);
      csr_write(CSR_DAMPING, damp);
      csr_write(CSR_CORNER_PREF, pref);
      csr_port.valid <= 1'b0;
   endtask

   task automatic noise_item();
      send_req(op_type'($urandom_range(0, 3)), any_coord(), any_coord(), any_coord(),
               any_coord(), coin(), coin(), coin());
   endtask

   task automatic random_frame();
      int cx, cy, w, h, l, t, n_hit, n_push;
      if ($urandom_range(0, 9) == 0) begin
         cx = $urandom_range(0, 1) ? -32768 : 32700;
         cy = $urandom_range(0, 1) ? -32768 : 32700;
      end else begin
         cx = int'($urandom_range(0, 4000)) - 2000;
         cy = int'($urandom_range(0, 4000)) - 2000;
      end
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, 40);
      h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, 40);
      send_req(OP_BEGIN, cx, cx + w, cy, cy + h, coin(), coin(), coin());
      n_hit  = $urandom_range(0, 4);
      n_push = $urandom_range(0, 5);
      repeat (n_hit) begin
         if ($urandom_range(0, 9) == 0) begin
            noise_item();
         end else begin
            l = cx - int'($urandom_range(0, 30)) + int'($urandom_range(0, w + 5));
            t = cy - int'($urandom_range(0, 30)) + int'($urandom_range(0, h + 5));
            send_req(OP_HIT, l, l + int'($urandom_range(0, w + 40)), t,
                     t + int'($urandom_range(0, h + 40)), coin(),
                     coin(), $urandom_range(0, 7) != 0);
         end
      end
      repeat (n_push) begin
         if ($urandom_range(0, 9) == 0) begin
            noise_item();
         end else begin
            l = cx - int'($urandom_range(0, w + 20));
            t = cy - int'($urandom_range(0, h + 20));
            if ($urandom_range(0, 7) == 0)
               send_req(OP_PUSH, l, l + int'($urandom_range(0, w)), t,
                        t + int'($urandom_range(0, h)), coin(), coin(), coin());
            else
               send_req(OP_PUSH, l, l + w + int'($urandom_range(0, 30)), t,
                        t + h + int'($urandom_range(0, 30)), coin(), coin(), coin());
         end
      end
      if ($urandom_range(0, 7) != 0)
         send_req(OP_FINAL, any_coord(), any_coord(), any_coord(), any_coord(),
                  coin(), coin(), coin());
   endtask

   task automatic run_phase(logic en, int damp, logic [1:0] pref, int n_items);
      int stop_at;
      set_config(en, damp, pref);
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         random_frame();
         if (idling && $urandom_range(0, 9) == 0) wait_drain();
      end
   endtask

   initial begin
      req_port.valid       <= 1'b0;
      req_port.opcode      <= OP_BEGIN;
      req_port.box_left    <= '0;
      req_port.box_right   <= '0;
      req_port.box_top     <= '0;
      req_port.box_bottom  <= '0;
      req_port.vx_positive <= 1'b0;
      req_port.vy_positive <= 1'b0;
      req_port.opp_enabled <= 1'b0;
      csr_port.valid       <= 1'b0;
      csr_port.index       <= CSR_SELF_EN;
      csr_port.data        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // full-range boxes: saturated overlaps, all four corners
      send_req(OP_BEGIN, -32768, 32767, -32768, 32767, 1'b1, 1'b1, 1'b0);
      send_req(OP_HIT, -32768, 32767, -32768, 32767, 1'b0, 1'b0, 1'b1);
      send_req(OP_PUSH, -32768, 32767, -32768, 32767, 1'b1, 1'b1, 1'b1);
      send_req(OP_FINAL, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
      // small self box, single corners, edges, skip and miss
      send_req(OP_BEGIN, 0, 9, 0, 9, 1'b0, 1'b0, 1'b1);
      send_req(OP_HIT, -5, 4, -5, 4, 1'b0, 1'b0, 1'b0);
      send_req(OP_HIT, -5, 4, -5, 4, 1'b0, 1'b0, 1'b1);
      send_req(OP_PUSH, -5, 4, -5, 4, 1'b0, 1'b0, 1'b0);
      send_req(OP_PUSH, 2, 3, 2, 3, 1'b0, 1'b0, 1'b0);
      send_req(OP_PUSH, 100, 200, 100, 200, 1'b0, 1'b0, 1'b0);
      send_req(OP_HIT, -5, 2, 3, 6, 1'b0, 1'b0, 1'b1);
      send_req(OP_HIT, 5, 20, -5, 4, 1'b0, 1'b0, 1'b1);
      send_req(OP_PUSH, -10, 20, -10, 3, 1'b0, 1'b0, 1'b0);
      send_req(OP_PUSH, 20, -20, 20, -20, 1'b0, 1'b0, 1'b0);
      send_req(OP_FINAL, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
      // inverted self box
      send_req(OP_BEGIN, 10, 0, 10, 0, 1'b1, 1'b0, 1'b0);
      send_req(OP_HIT, -32768, 32767, -32768, 32767, 1'b1, 1'b1, 1'b1);
      send_req(OP_PUSH, 5, 20, 5, 20, 1'b0, 1'b1, 1'b0);
      send_req(OP_FINAL, -1, -1, -1, -1, 1'b1, 1'b1, 1'b1);
      // two diagonal corners, velocity decides the direction
      send_req(OP_BEGIN, 0, 9, 0, 9, 1'b1, 1'b0, 1'b0);
      send_req(OP_HIT, -5, 2, -5, 2, 1'b0, 1'b0, 1'b1);
      send_req(OP_HIT, 7, 15, 7, 15, 1'b0, 1'b0, 1'b1);
      send_req(OP_PUSH, -3, 12, -4, 12, 1'b0, 1'b0, 1'b0);
      send_req(OP_FINAL, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0);

      run_phase(1'b1, DAMP_ONE, PREF_X, 75);
      run_phase(1'b1, 128, PREF_Y, 75);
      run_phase(1'b0, DAMP_ONE, PREF_BOTH, 60);
      run_phase(1'b1, 0, PREF_SPARE, 70);
      run_phase(1'b1, 511, PREF_BOTH, 70);
      run_phase(1'b1, 300, PREF_X, 70);
      wait_drain();
      @(negedge clock);
      idling = 1'b0;
      run_phase(1'b1, DAMP_ONE, PREF_Y, 90);
      wait_drain();

      if (error_count == 0) begin
         $display("aabb_contact_pushback_core_tb: clean");
      end else begin
         $display("aabb_contact_pushback_core_tb: errors");
      end
      $finish;
   end

endmodule
